// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the chime generator checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when pre holds, post holds on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/dscg_pkg.sv
// ----------------------------------------------------------------------------
// dscg_pkg
// widths, fixed-point formats and the sine table of the chime generator
// ----------------------------------------------------------------------------
package dscg_pkg;

  localparam int SINE_TABLE_ADDR_BITS = 10;
  localparam int ENVELOPE_FRAC_BITS   = 24;

  localparam int ROM_SIZE     = 1 << SINE_TABLE_ADDR_BITS;
  localparam int QUARTER_BITS = SINE_TABLE_ADDR_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int SAMPLE_W     = 16;
  localparam int MAG_W        = 15;
  localparam int PHASE_W      = 32;
  localparam int PHASE_STEP_W = 31;
  localparam int LEN_W        = 16;
  localparam int STEP_W       = 25;
  localparam int AMP_W        = 15;
  localparam int ENV_W        = ENVELOPE_FRAC_BITS + 1;
  localparam int CLAMP_W      = (STEP_W > ENV_W) ? STEP_W : ENV_W;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  // serial multiplier: widest multiplicand is amplitude times gain
  localparam int MUL_MC_W   = ENVELOPE_FRAC_BITS + AMP_W + 1;
  localparam int MUL_MP_W   = ENV_W;
  localparam int MUL_PROD_W = MUL_MC_W + MUL_MP_W;
  localparam int MUL_CNT_W  = $clog2(MUL_MP_W);

  typedef logic [ROM_SIZE-1:0][SAMPLE_W-1:0] sine_rom_t;

  // restoring long division, only used while the table is built
  function automatic longint unsigned table_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine in q15, taylor series up to x^15 with x in q30
  function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint          acc;
    x    = (r * HALF_PI_Q30) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = table_div((term * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = (longint'(unsigned'(acc)) * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) begin
      v = 32767;
    end
    return v[MAG_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    int              quad;
    int              r;
    logic [MAG_W-1:0] v;
    logic [SAMPLE_W-1:0] v16;
    for (int k = 0; k < ROM_SIZE; k++) begin
      quad = k >> QUARTER_BITS;
      r    = k & (QUARTER - 1);
      if ((quad % 2) == 1) begin
        v = quarter_sine(longint'(QUARTER - r));
      end else begin
        v = quarter_sine(longint'(r));
      end
      v16 = {1'b0, v};
      rom[k] = (quad >= 2) ? (~v16 + 1'b1) : v16;
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: hdl/dscg_serial_mult.sv
// ----------------------------------------------------------------------------
// dscg_serial_mult
// unsigned shift-add multiplier, one multiplier bit per clock, lsb first
// ----------------------------------------------------------------------------
module dscg_serial_mult (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [dscg_pkg::MUL_MC_W-1:0]    mcand_i,
  input  logic [dscg_pkg::MUL_MP_W-1:0]    mplier_i,
  output logic                             done_o,
  output logic [dscg_pkg::MUL_PROD_W-1:0]  prod_o
);
  import dscg_pkg::*;

  logic [MUL_MC_W-1:0]  mcand_q;
  logic [MUL_MC_W-1:0]  hi_q, hi_d;
  logic [MUL_MP_W-1:0]  lo_q, lo_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_MC_W:0]    sum;

  // partial sum of the upper half, then one step to the right
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);

  always_comb begin
    hi_d   = hi_q;
    lo_d   = lo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      hi_d   = '0;
      lo_d   = mplier_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      hi_d  = sum[MUL_MC_W:1];
      lo_d  = {sum[0], lo_q[MUL_MP_W-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_MP_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (start_i) begin
      mcand_q <= mcand_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// File: hdl/dscg_sine_rom.sv
// ----------------------------------------------------------------------------
// dscg_sine_rom
// full-wave q1.15 sine table with registered read
// ----------------------------------------------------------------------------
module dscg_sine_rom (
  input  logic                                     clk_i,
  input  logic [dscg_pkg::SINE_TABLE_ADDR_BITS-1:0] addr_i,
  output logic [dscg_pkg::SAMPLE_W-1:0]            data_o
);
  import dscg_pkg::*;

  logic [SAMPLE_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= SINE_ROM[addr_i];
  end

  assign data_o = data_q;

endmodule

// File: hdl/decaying_sine_chime_generator.sv
// ----------------------------------------------------------------------------
// decaying_sine_chime_generator
// sine chime source with linear attack and exponential decay envelope
// ----------------------------------------------------------------------------
// One input request is one audio sample tick and always yields exactly one
// result: a signed 16-bit sample with active and last flags. A start request
// on an idle tick begins a note whose first sample comes out for that same
// tick; starts during a note are ignored. Idle ticks give a zero sample.
// For a note sample the gain, amplitude and sine products run one after the
// other on one bit-serial multiplier, one multiplier bit per clock, while the
// next decay envelope is formed on a second serial multiplier alongside. The
// finished sample sits in an output register, so the next request is taken
// while a sample still waits downstream. Register writes are taken at any
// time (cfg_ready_o stays high) but belong between requests; they act from
// the next sample on. Register indexes beyond the list are ignored.
// ----------------------------------------------------------------------------
module decaying_sine_chime_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // sample tick requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              start_req_i,
  // sample results
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [dscg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                              active_o,
  output logic                              last_o,
  // register writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dscg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dscg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import dscg_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_ATTACK_LENGTH = 3'd1,
    REG_ATTACK_STEP   = 3'd2,
    REG_DECAY_FACTOR  = 3'd3,
    REG_AMPLITUDE     = 3'd4,
    REG_NOTE_LENGTH   = 3'd5
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_ROM      = 6'b000010,
    ST_MUL_GAIN = 6'b000100,
    ST_MUL_AMP  = 6'b001000,
    ST_MUL_SINE = 6'b010000,
    ST_FIN      = 6'b100000
  } state_e;

  localparam int RAMP_SUM_W = CLAMP_W + 1;
  localparam int MAG_FULL_W = MUL_PROD_W - ENVELOPE_FRAC_BITS - MAG_W;
  localparam logic [ENV_W-1:0]      ENV_ONE   = {1'b1, {ENVELOPE_FRAC_BITS{1'b0}}};
  localparam logic [CLAMP_W-1:0]    ONE_CLAMP = CLAMP_W'(ENV_ONE);
  localparam logic [RAMP_SUM_W-1:0] ONE_SUM   = RAMP_SUM_W'(ENV_ONE);

  // configuration registers
  logic [PHASE_STEP_W-1:0] phase_step_q;
  logic [LEN_W-1:0]        attack_len_q;
  logic [STEP_W-1:0]       attack_step_q;
  logic [STEP_W-1:0]       decay_q;
  logic [AMP_W-1:0]        amp_q;
  logic [LEN_W-1:0]        note_len_q;

  // note state
  logic [LEN_W-1:0]   index_q, index_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [ENV_W-1:0]   env_q, env_d;
  logic [ENV_W-1:0]   ramp_q, ramp_d;
  logic               playing_q, playing_d;

  state_e state_q, state_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       active_q;
  logic                       last_q;

  logic in_accept;
  logic out_load;

  // multiplier hookup
  logic                  start_a;
  logic [MUL_MC_W-1:0]   mcand_a;
  logic [MUL_MP_W-1:0]   mplier_a;
  logic                  done_a;
  logic [MUL_PROD_W-1:0] prod_a;
  logic [MUL_MC_W-1:0]   mcand_b;
  logic [MUL_MP_W-1:0]   mplier_b;
  logic                  done_b;
  logic [MUL_PROD_W-1:0] prod_b;

  logic [SAMPLE_W-1:0] rom_data;
  logic [SAMPLE_W-1:0] rom_neg;
  logic                neg;
  logic [MAG_W-1:0]    smag;

  logic [ENV_W-1:0]      att;
  logic [CLAMP_W-1:0]    decay_ext;
  logic [ENV_W-1:0]      dec;
  logic [RAMP_SUM_W-1:0] ramp_sum;
  logic [ENV_W-1:0]      ramp_next;
  logic                  is_last;
  logic [MAG_FULL_W-1:0] mag_full;
  logic [MAG_W-1:0]      mag_sat;
  logic [SAMPLE_W-1:0]   mag16;
  logic [SAMPLE_W-1:0]   sample_res;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= 31'd101920253;
      attack_len_q  <= 16'd220;
      attack_step_q <= 25'd76260;
      decay_q       <= 25'd16775314;
      amp_q         <= 15'd22937;
      note_len_q    <= 16'd26460;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PHASE_STEP:    phase_step_q  <= cfg_data_i[PHASE_STEP_W-1:0];
        REG_ATTACK_LENGTH: attack_len_q  <= cfg_data_i[LEN_W-1:0];
        REG_ATTACK_STEP:   attack_step_q <= cfg_data_i[STEP_W-1:0];
        REG_DECAY_FACTOR:  decay_q       <= cfg_data_i[STEP_W-1:0];
        REG_AMPLITUDE:     amp_q         <= cfg_data_i[AMP_W-1:0];
        REG_NOTE_LENGTH:   note_len_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sine lookup, address stays put from note setup until the sample is out
  dscg_sine_rom u_rom (
    .clk_i  (clk_i),
    .addr_i (phase_q[PHASE_W-1 -: SINE_TABLE_ADDR_BITS]),
    .data_o (rom_data)
  );

  assign neg     = rom_data[SAMPLE_W-1];
  assign rom_neg = ~rom_data + 1'b1;
  assign smag    = neg ? rom_neg[MAG_W-1:0] : rom_data[MAG_W-1:0];

  // attack level, full once past the ramp
  assign att = (index_q >= attack_len_q) ? ENV_ONE : ramp_q;

  // decay factor limited to one
  assign decay_ext = CLAMP_W'(decay_q);
  always_comb begin
    if (decay_ext > ONE_CLAMP) begin
      dec = ENV_ONE;
    end else begin
      dec = decay_ext[ENV_W-1:0];
    end
  end

  assign ramp_sum = RAMP_SUM_W'(ramp_q) + RAMP_SUM_W'(attack_step_q);
  assign ramp_next = (ramp_sum > ONE_SUM) ? ENV_ONE : ramp_sum[ENV_W-1:0];

  assign is_last = (index_q == (note_len_q - 1'b1));

  // operand select for the shared unit: gain, then amplitude, then sine
  always_comb begin
    start_a  = 1'b0;
    mcand_a  = {{(MUL_MC_W - ENV_W){1'b0}}, env_q};
    mplier_a = att;
    case (state_q)
      ST_ROM: begin
        start_a = 1'b1;
      end
      ST_MUL_GAIN: begin
        start_a  = done_a;
        mcand_a  = {{(MUL_MC_W - ENV_W){1'b0}}, prod_a[ENVELOPE_FRAC_BITS +: ENV_W]};
        mplier_a = {{(MUL_MP_W - AMP_W){1'b0}}, amp_q};
      end
      ST_MUL_AMP: begin
        start_a  = done_a;
        mcand_a  = prod_a[MUL_MC_W-1:0];
        mplier_a = {{(MUL_MP_W - MAG_W){1'b0}}, smag};
      end
      default: ;
    endcase
  end

  dscg_serial_mult u_mul_gain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_a),
    .mcand_i  (mcand_a),
    .mplier_i (mplier_a),
    .done_o   (done_a),
    .prod_o   (prod_a)
  );

  // next decay envelope, runs alongside the gain chain
  assign mcand_b  = {{(MUL_MC_W - ENV_W){1'b0}}, env_q};
  assign mplier_b = dec;

  dscg_serial_mult u_mul_decay (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == ST_ROM),
    .mcand_i  (mcand_b),
    .mplier_i (mplier_b),
    .done_o   (done_b),
    .prod_o   (prod_b)
  );

  // magnitude after the final shift, clamped to full scale
  assign mag_full = prod_a[MUL_PROD_W-1 -: MAG_FULL_W];
  assign mag_sat  = (|mag_full[MAG_FULL_W-1:MAG_W]) ? '1 : mag_full[MAG_W-1:0];
  assign mag16    = {1'b0, mag_sat};
  assign sample_res = neg ? (~mag16 + 1'b1) : mag16;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (playing_q || start_req_i) ? ST_ROM : ST_FIN;
        end
      end
      ST_ROM:      state_d = ST_MUL_GAIN;
      ST_MUL_GAIN: if (done_a) state_d = ST_MUL_AMP;
      ST_MUL_AMP:  if (done_a) state_d = ST_MUL_SINE;
      ST_MUL_SINE: if (done_a && done_b) state_d = ST_FIN;
      ST_FIN:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // note state: set up on a start, stepped once the sample is loaded into the output register
  always_comb begin
    index_d   = index_q;
    phase_d   = phase_q;
    env_d     = env_q;
    ramp_d    = ramp_q;
    playing_d = playing_q;
    if (in_accept && !playing_q && start_req_i) begin
      playing_d = 1'b1;
      index_d   = '0;
      phase_d   = '0;
      env_d     = ENV_ONE;
      ramp_d    = '0;
    end else if (out_load && playing_q) begin
      index_d = index_q + 1'b1;
      phase_d = phase_q + {1'b0, phase_step_q};
      env_d   = prod_b[ENVELOPE_FRAC_BITS +: ENV_W];
      ramp_d  = ramp_next;
      if (is_last) begin
        playing_d = 1'b0;
      end
    end
  end

  // result leaves through the output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      index_q     <= '0;
      phase_q     <= '0;
      env_q       <= '0;
      ramp_q      <= '0;
      playing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      index_q     <= index_d;
      phase_q     <= phase_d;
      env_q       <= env_d;
      ramp_q      <= ramp_d;
      playing_q   <= playing_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= playing_q ? signed'(sample_res) : '0;
      active_q <= playing_q;
      last_q   <= playing_q && is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign active_o    = active_q;
  assign last_o      = last_q;

endmodule

// File: hdl/dscg_checker.sv
// ----------------------------------------------------------------------------
// dscg_checker
// port-level checks of the chime generator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dscg_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [dscg_pkg::SAMPLE_W-1:0] sample_o,
  input logic                                 active_o,
  input logic                                 last_o
);
  import dscg_pkg::*;

  // a last flag only on a note sample
  `ASSERT_PROP(last_needs_active_a, clk_i, rst_ni, out_valid_o && last_o |-> active_o, "last without active")

  // idle ticks are silent
  `ASSERT_PROP(idle_silent_a, clk_i, rst_ni, out_valid_o && !active_o |-> sample_o == '0 && !last_o, "idle sample not zero")

  // clamp keeps the negative full-scale code out
  `ASSERT_PROP(no_neg_full_a, clk_i, rst_ni, out_valid_o |-> !(sample_o[SAMPLE_W-1] && (sample_o[SAMPLE_W-2:0] == '0)), "sample below -32767")

  // one request in flight: the port closes right after a request is taken
  `ASSERT_NEXT(one_in_flight_a, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")

  // a stalled result holds
  `ASSERT_NEXT(result_holds_a, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(sample_o) && $stable(active_o) && $stable(last_o), "stalled result changed")

endmodule

bind decaying_sine_chime_generator dscg_checker u_dscg_checker (.*);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the decaying sine chime generator
// ----------------------------------------------------------------------------
// Every sample tick sent in is run through a cycle-free model of the chime:
// its own quarter-wave sine table, attack ramp, decay envelope and note
// counter. The expected sample, active and last flags are queued. A monitor
// compares each delivered sample with the oldest entry. Register settings
// are changed only while nothing is in flight. Both sides idle at random,
// one stretch runs at full rate, and one long output hold-off fills the
// block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dscg_pkg::*;

  // table and envelope formats
  localparam int              ADDR_BITS   = SINE_TABLE_ADDR_BITS;
  localparam int              FRAC        = ENVELOPE_FRAC_BITS;
  localparam int              TONE_SIZE   = 1 << ADDR_BITS;
  localparam int              QTR_BITS    = ADDR_BITS - 2;
  localparam int              QTR         = 1 << QTR_BITS;
  localparam longint unsigned ENV_ONE     = 64'd1 << FRAC;
  localparam longint unsigned HALF_PI     = 64'd1686629713;

  // run control
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;
  localparam int IDLE_PCT    = 38;

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP,
    REG_ATTACK_LEN,
    REG_ATTACK_STEP,
    REG_DECAY,
    REG_AMPLITUDE,
    REG_NOTE_LEN,
    REG_SPARE_6,
    REG_SPARE_7
  } cfg_reg_e;

  // one delivered sample
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic                       last;
  } chime_sample_t;

  // ports
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic                         start_req_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_o;
  logic                         active_o;
  logic                         last_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]        cfg_data_i  = '0;

  // model copy of the registers
  logic [PHASE_STEP_W-1:0] phase_inc;
  logic [LEN_W-1:0]        atk_len;
  logic [STEP_W-1:0]       atk_step;
  logic [STEP_W-1:0]       decay_mul;
  logic [AMP_W-1:0]        peak_amp;
  logic [LEN_W-1:0]        note_len;

  // model copy of the note state
  logic [LEN_W-1:0]        note_idx;
  logic [PHASE_W-1:0]      note_phase;
  logic [ENV_W-1:0]        env_level;
  logic [ENV_W-1:0]        ramp_level;
  logic                    note_on;

  logic signed [SAMPLE_W-1:0] tone_table [TONE_SIZE];

  // samples still owed by the block, oldest first
  chime_sample_t chime_expect [$];

  // bookkeeping
  int mismatches     = 0;
  int ticks_sent     = 0;
  int samples_seen   = 0;
  int notes_started  = 0;
  int notes_ended    = 0;
  int cfg_writes     = 0;
  int stalled_cycles = 0;
  int cycle_count    = 0;
  bit steady         = 1'b0;   // no random idling on either side
  int hold_asks      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  decaying_sine_chime_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .active_o    (active_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- tone table

  // q15 sine of a quarter-wave position, taylor series to x^15 in q30
  function automatic longint unsigned quarter_wave(input longint unsigned pos);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned tv;
    longint unsigned div;
    longint unsigned q15;
    longint          acc;
    ang    = (pos * HALF_PI) >> QTR_BITS;
    ang_sq = (ang * ang) >> 30;
    tv     = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      div = longint'((2 * n) * (2 * n + 1));
      tv  = ((tv * ang_sq) >> 30) / div;
      if (n % 2 == 1) begin
        acc = acc - longint'(tv);
      end else begin
        acc = acc + longint'(tv);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q15 = (longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    return (q15 > 32767) ? 64'd32767 : q15;
  endfunction

  // full wave from the quarter: mirror odd quadrants, negate the lower half
  function automatic void build_tone_table();
    int              quad;
    int              r;
    longint unsigned v;
    for (int k = 0; k < TONE_SIZE; k++) begin
      quad = k >> QTR_BITS;
      r    = k & (QTR - 1);
      v    = (quad % 2 == 1) ? quarter_wave(longint'(QTR - r)) : quarter_wave(longint'(r));
      tone_table[k] = (quad >= 2) ? -SAMPLE_W'(v) : SAMPLE_W'(v);
    end
  endfunction

  // ---------------------------------------------------------------- model

  // register values after reset, note state cleared
  function automatic void load_reset_values();
    phase_inc  = 31'd101920253;
    atk_len    = 16'd220;
    atk_step   = 25'd76260;
    decay_mul  = 25'd16775314;
    peak_amp   = 15'd22937;
    note_len   = 16'd26460;
    note_idx   = '0;
    note_phase = '0;
    env_level  = '0;
    ramp_level = '0;
    note_on    = 1'b0;
  endfunction

  // one sample tick: start a note if idle, emit the sample, advance the note
  function automatic chime_sample_t next_chime_sample(input logic start);
    chime_sample_t   res;
    int              tone;
    longint unsigned tone_mag;
    longint unsigned att;
    longint unsigned gain;
    longint unsigned mag;
    longint unsigned ramp_sum;
    longint unsigned dec;
    logic [LEN_W-1:0] last_idx;
    logic            is_last;
    res = '0;
    if (!note_on && start) begin
      note_on    = 1'b1;
      note_idx   = '0;
      note_phase = '0;
      env_level  = ENV_W'(ENV_ONE);
      ramp_level = '0;
      notes_started++;
    end
    if (note_on) begin
      tone     = tone_table[note_phase[PHASE_W-1 -: ADDR_BITS]];
      tone_mag = (tone < 0) ? longint'(-tone) : longint'(tone);
      // attack ramp only inside the attack window, capped at full level
      if (note_idx >= atk_len) begin
        att = ENV_ONE;
      end else begin
        att = (ramp_level > ENV_ONE) ? ENV_ONE : ramp_level;
      end
      gain = (att * env_level) >> FRAC;
      mag  = (peak_amp * gain * tone_mag) >> (FRAC + 15);
      if (mag > 32767) begin
        mag = 32767;
      end
      // length zero wraps to the 65536th sample
      last_idx   = note_len - 16'd1;
      is_last    = (note_idx == last_idx);
      res.sample = SAMPLE_W'(mag);
      if (tone < 0) begin
        res.sample = -res.sample;
      end
      res.active = 1'b1;
      res.last   = is_last;
      // advance for the next tick
      note_phase = note_phase + {1'b0, phase_inc};
      ramp_sum   = ramp_level + atk_step;
      ramp_level = ENV_W'((ramp_sum > ENV_ONE) ? ENV_ONE : ramp_sum);
      dec        = (decay_mul > ENV_ONE) ? ENV_ONE : decay_mul;
      env_level  = ENV_W'((env_level * dec) >> FRAC);
      note_idx   = note_idx + 16'd1;
      if (is_last) begin
        note_on = 1'b0;
        notes_ended++;
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] sample %0d: %0s got %0d expected %0d", $realtime, samples_seen, what,
             got, want);
  endtask

  // compare each delivered sample with the oldest one owed
  always @(posedge clk_i) begin : check_samples
    chime_sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (chime_expect.size() == 0) begin
        report_mismatch("unrequested sample", sample_o, 0);
      end else begin
        want = chime_expect.pop_front();
        if (sample_o !== want.sample) begin
          report_mismatch("sample", sample_o, want.sample);
        end
        if (active_o !== want.active) begin
          report_mismatch("active", active_o, want.active);
        end
        if (last_o !== want.last) begin
          report_mismatch("last", last_o, want.last);
        end
      end
      samples_seen++;
    end
  end

  // downstream stalls: random, or one long hold-off when a test asks
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || (!steady && $urandom_range(0, 99) < IDLE_PCT);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers

  // one sample tick request; valid stays up for a following tick
  task automatic send_tick(input logic start);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    start_req_i <= start;
    @(posedge clk_i);
    while (in_stall_o) begin
      stalled_cycles++;
      @(posedge clk_i);
    end
    chime_expect.push_back(next_chime_sample(start));
    ticks_sent++;
  endtask

  task automatic wait_drained();
    while (chime_expect.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // end of a burst: drop valid, let every owed sample come out
  task automatic finish_burst();
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  // mostly start requests, which only take effect between notes
  task automatic run_ticks(input int count);
    repeat (count) begin
      send_tick($urandom_range(0, 3) != 0);
    end
    finish_burst();
  endtask

  // register write; valid is left up for a following write
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      REG_PHASE_STEP:  phase_inc = data[PHASE_STEP_W-1:0];
      REG_ATTACK_LEN:  atk_len   = data[LEN_W-1:0];
      REG_ATTACK_STEP: atk_step  = data[STEP_W-1:0];
      REG_DECAY:       decay_mul = data[STEP_W-1:0];
      REG_AMPLITUDE:   peak_amp  = data[AMP_W-1:0];
      REG_NOTE_LEN:    note_len  = data[LEN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_all(input logic [31:0] ps, input logic [31:0] alen,
                         input logic [31:0] astep, input logic [31:0] dfac,
                         input logic [31:0] amp, input logic [31:0] nlen);
    write_reg(REG_PHASE_STEP, ps);
    write_reg(REG_ATTACK_LEN, alen);
    write_reg(REG_ATTACK_STEP, astep);
    write_reg(REG_DECAY, dfac);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_NOTE_LEN, nlen);
    cfg_valid_i <= 1'b0;
  endtask

  // random settings with junk above each field; a note still playing is
  // given a length that ends it soon
  task automatic randomize_settings();
    logic [LEN_W-1:0]  alen;
    logic [LEN_W-1:0]  nlen;
    logic [STEP_W-1:0] astep;
    logic [STEP_W-1:0] dfac;
    logic [AMP_W-1:0]  amp;
    case ($urandom_range(0, 3))
      0:       alen = '0;
      1:       alen = LEN_W'($urandom_range(1, 8));
      2:       alen = LEN_W'($urandom_range(9, 60));
      default: alen = LEN_W'($urandom());
    endcase
    case ($urandom_range(0, 3))
      0:       astep = STEP_W'(ENV_ONE / ((alen == 0) ? 64'd1 : longint'(alen)));
      1:       astep = STEP_W'($urandom());
      2:       astep = STEP_W'(ENV_ONE);
      default: astep = STEP_W'($urandom_range(0, 4096));
    endcase
    case ($urandom_range(0, 4))
      0:       dfac = STEP_W'(ENV_ONE - $urandom_range(0, 1 << 20));
      1:       dfac = STEP_W'($urandom());
      2:       dfac = STEP_W'(ENV_ONE);
      3:       dfac = '0;
      default: dfac = STEP_W'(ENV_ONE - $urandom_range(0, 1 << 14));
    endcase
    case ($urandom_range(0, 7))
      0:       amp = '0;
      1:       amp = '1;
      default: amp = AMP_W'($urandom());
    endcase
    if (note_on) begin
      nlen = note_idx + LEN_W'($urandom_range(1, 24));
    end else begin
      case ($urandom_range(0, 7))
        0:       nlen = 16'd1;
        1:       nlen = LEN_W'($urandom());
        default: nlen = LEN_W'($urandom_range(2, 30));
      endcase
    end
    if ($urandom_range(0, 5) == 0) begin
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
    end
    set_all($urandom(), {16'($urandom()), alen}, {7'($urandom()), astep},
            {7'($urandom()), dfac}, {17'($urandom()), amp}, {16'($urandom()), nlen});
  endtask

  // ---------------------------------------------------------------- tests

  // reset settings, idle ticks, starts during a note ignored, cut-short end
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    finish_burst();
    // shorten the note from the middle: two more samples, the second last
    write_reg(REG_NOTE_LEN, 32'(note_idx) + 32'd2);
    cfg_valid_i <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    finish_burst();
  endtask

  task automatic test_directed_corners();
    // one-sample notes back to back, widest phase step, decay above one
    set_all(32'h7FFF_FFFF, 32'd0, 32'd0, 32'h01FF_FFFF, 32'd32767, 32'd1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    finish_burst();
    // quarter-cycle steps hit the peaks, attack ramp saturates at full level
    set_all(32'h4000_0000, 32'd65535, 32'h01FF_FFFF, 32'(ENV_ONE), 32'd32767, 32'd4);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    finish_burst();
    // zero decay factor and zero note length, then cut the note short
    set_all(32'h2000_0000, 32'd3, 32'(ENV_ONE), 32'd0, 32'd32767, 32'd0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    finish_burst();
    write_reg(REG_NOTE_LEN, 32'(note_idx) + 32'd1);
    cfg_valid_i <= 1'b0;
    send_tick(1'b0);
    finish_burst();
    // writes to indexes past the list must change nothing
    set_all(32'h0123_4567, 32'd2, 32'h0080_0000, 32'h00FF_0000, 32'd20000, 32'd3);
    @(posedge clk_i);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    cfg_valid_i <= 1'b0;
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    finish_burst();
  endtask

  task automatic test_random_notes();
    int goal;
    goal = ticks_sent + 300;
    while (ticks_sent < goal) begin
      randomize_settings();
      run_ticks($urandom_range(4, 40));
    end
  endtask

  // no idling on either side
  task automatic test_full_rate();
    steady = 1'b1;
    repeat (3) begin
      randomize_settings();
      run_ticks(20);
    end
    steady = 1'b0;
  endtask

  // long downstream hold-off while ticks keep coming
  task automatic test_back_pressure();
    randomize_settings();
    hold_asks <= hold_asks + 1;
    run_ticks(30);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    build_tone_table();
    load_reset_values();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed_corners();
    test_random_notes();
    test_full_rate();
    test_back_pressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d ticks, %0d samples, %0d notes started, %0d ended, %0d reg writes",
             ticks_sent, samples_seen, notes_started, notes_ended, cfg_writes);
    $display("input stalled %0d cycles, %0d mismatches", stalled_cycles, mismatches);
    if (mismatches == 0 && chime_expect.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: decaying_sine_chime_generator.f
+incdir+hdl
hdl/dscg_pkg.sv
hdl/dscg_serial_mult.sv
hdl/dscg_sine_rom.sv
hdl/decaying_sine_chime_generator.sv
hdl/dscg_checker.sv
bench/tb.sv
